// File: rtl/core/lspi_pkg.sv
package lspi_pkg;

  // item kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_SWITCH = 2'd1;
  localparam logic [1:0] KIND_GOAL   = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN        = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN        = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_SPEED   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGN_MODE      = 4'd7;
  localparam int CFG_DATA_W = 24;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] encoder_delta;
    logic               end_position;
    logic               switch_active;
  } in_item_t;

  typedef struct packed {
    logic [15:0] duty;
    logic        direction;
    logic        at_goal;
  } out_item_t;

  typedef struct packed {
    logic [23:0] kp_gain;
    logic [23:0] ki_gain;
    logic [23:0] integral_limit;
    logic [23:0] sample_period;
    logic [23:0] speed_scale;
    logic [15:0] pwm_period;
    logic [23:0] travel_speed;
    logic [1:0]  sign_mode;
  } cfg_t;

  // microcode
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_DISPATCH,
    OP_SPEED,
    OP_ERR,
    OP_INTEG,
    OP_SUM_LOAD,
    OP_SUM_ADD,
    OP_DRIVE,
    OP_DUTY
  } alu_op_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ENC_SCALE,
    MUL_ERR_PERIOD,
    MUL_KI_INTEG,
    MUL_KP_ERR,
    MUL_MAG_PWM
  } mul_sel_t;

  typedef enum logic {
    JMP_NONE,
    JMP_NOT_TICK
  } jmp_t;

  typedef struct packed {
    alu_op_t  op;
    mul_sel_t mul;
    jmp_t     jmp;
    step_t    target;
    logic     last;
  } ucw_t;

  localparam step_t STEP_EMIT = 4'd11;

endpackage

// File: rtl/core/lspi_ucode_rom.sv
module lspi_ucode_rom (
  input  lspi_pkg::step_t step,
  output lspi_pkg::ucw_t  ucw
);
  import lspi_pkg::*;

  // control program: a tick runs the whole loop, other kinds skip to the emit step
  always_comb begin
    ucw = '{op: OP_NOP, mul: MUL_NONE, jmp: JMP_NONE, target: '0, last: 1'b0};
    case (step)
      4'd0: begin
        ucw.op     = OP_DISPATCH;
        ucw.mul    = MUL_ENC_SCALE;
        ucw.jmp    = JMP_NOT_TICK;
        ucw.target = STEP_EMIT;
      end
      4'd1:  ucw.op  = OP_SPEED;
      4'd2:  ucw.op  = OP_ERR;
      4'd3:  ucw.mul = MUL_ERR_PERIOD;
      4'd4:  ucw.op  = OP_INTEG;
      4'd5:  ucw.mul = MUL_KI_INTEG;
      4'd6: begin
        ucw.op  = OP_SUM_LOAD;
        ucw.mul = MUL_KP_ERR;
      end
      4'd7:  ucw.op  = OP_SUM_ADD;
      4'd8:  ucw.op  = OP_DRIVE;
      4'd9:  ucw.mul = MUL_MAG_PWM;
      4'd10: ucw.op  = OP_DUTY;
      STEP_EMIT: ucw.last = 1'b1;
      default: ucw.last = 1'b1;
    endcase
  end

endmodule

// File: rtl/core/lspi_datapath.sv
module lspi_datapath (
  input  logic                clk,
  input  logic                rst,
  input  lspi_pkg::cfg_t      cfg,
  input  logic                load,
  input  lspi_pkg::in_item_t  item,
  input  logic                exec,
  input  lspi_pkg::ucw_t      ucw,
  output logic                is_tick,
  output lspi_pkg::out_item_t result
);
  import lspi_pkg::*;

  localparam logic signed [32:0] S32_MAX = 33'sh0_7FFF_FFFF;
  localparam logic signed [32:0] S32_MIN = 33'sh1_8000_0000;
  localparam logic signed [41:0] DRV_MAX = 42'sd65536;
  localparam logic signed [41:0] DRV_MIN = -42'sd65536;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = S32_MAX[31:0];
    else if (v < S32_MIN) r = S32_MIN[31:0];
    else r = v[31:0];
    return r;
  endfunction

  in_item_t           item_q;
  logic signed [57:0] prod;
  logic signed [57:0] sum;
  logic signed [31:0] speed;
  logic signed [31:0] err;
  logic signed [24:0] integ_acc;
  logic [16:0]        mag;
  logic [15:0]        duty_held;
  logic               dir_held;
  logic               pos_now;
  logic               pos_goal;

  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;

  logic signed [31:0] spd_raw;
  logic signed [32:0] spd_ext;
  logic signed [24:0] travel;
  logic signed [24:0] setpoint;
  logic signed [32:0] diff;
  logic signed [31:0] integ_inc;
  logic signed [32:0] integ_sum;
  logic signed [32:0] lim;
  logic signed [32:0] integ_sel;
  logic signed [41:0] drv_raw;
  logic signed [17:0] drv_clamp;
  logic signed [17:0] drv_neg;

  assign is_tick = (item_q.kind == KIND_TICK);
  assign result  = '{duty: duty_held, direction: dir_held, at_goal: (pos_now == pos_goal)};

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ucw.mul)
      MUL_ENC_SCALE: begin
        mul_a = {{17{item_q.encoder_delta[15]}}, item_q.encoder_delta};
        mul_b = {1'b0, cfg.speed_scale};
      end
      MUL_ERR_PERIOD: begin
        mul_a = {err[31], err};
        mul_b = {1'b0, cfg.sample_period};
      end
      MUL_KI_INTEG: begin
        mul_a = {9'b0, cfg.ki_gain};
        mul_b = integ_acc;
      end
      MUL_KP_ERR: begin
        mul_a = {err[31], err};
        mul_b = {1'b0, cfg.kp_gain};
      end
      MUL_MAG_PWM: begin
        mul_a = {16'b0, mag};
        mul_b = {9'b0, cfg.pwm_period};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // alu paths
  always_comb begin
    spd_raw = prod[39:8];
    spd_ext = cfg.sign_mode[0] ? -{spd_raw[31], spd_raw} : {spd_raw[31], spd_raw};

    travel = $signed({1'b0, cfg.travel_speed});
    if (pos_now != pos_goal) setpoint = pos_now ? travel : -travel;
    else setpoint = '0;
    if (cfg.sign_mode[1]) setpoint = -setpoint;
    diff = {{8{setpoint[24]}}, setpoint} - {speed[31], speed};

    integ_inc = prod[55:24];
    integ_sum = {{8{integ_acc[24]}}, integ_acc} + {integ_inc[31], integ_inc};
    lim       = $signed({9'b0, cfg.integral_limit});
    if (integ_sum > lim) integ_sel = lim;
    else if (integ_sum < -lim) integ_sel = -lim;
    else integ_sel = integ_sum;

    drv_raw = sum[57:16];
    if (drv_raw > DRV_MAX) drv_clamp = DRV_MAX[17:0];
    else if (drv_raw < DRV_MIN) drv_clamp = DRV_MIN[17:0];
    else drv_clamp = drv_raw[17:0];
    drv_neg = -drv_clamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc <= '0;
      duty_held <= '0;
      dir_held  <= 1'b0;
      pos_now   <= 1'b0;
      pos_goal  <= 1'b0;
    end else begin
      if (load) item_q <= item;
      if (exec) begin
        if (ucw.mul != MUL_NONE) prod <= mul_a * mul_b;
        case (ucw.op)
          OP_DISPATCH: begin
            if (item_q.kind == KIND_SWITCH && item_q.switch_active)
              pos_now <= item_q.end_position;
            if (item_q.kind == KIND_GOAL)
              pos_goal <= item_q.end_position;
          end
          OP_SPEED:    speed <= sat32(spd_ext);
          OP_ERR:      err <= sat32(diff);
          OP_INTEG:    integ_acc <= integ_sel[24:0];
          OP_SUM_LOAD: sum <= prod;
          OP_SUM_ADD:  sum <= sum + prod;
          OP_DRIVE: begin
            mag   <= drv_clamp[17] ? drv_neg[16:0] : drv_clamp[16:0];
            if (drv_clamp != '0) dir_held <= ~drv_clamp[17];
          end
          OP_DUTY:     duty_held <= prod[31:16];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/core/lspi_sequencer.sv
module lspi_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  output logic                load,
  output logic                exec,
  output lspi_pkg::step_t     step,
  input  lspi_pkg::ucw_t      ucw,
  input  logic                is_tick,
  input  lspi_pkg::out_item_t result,
  output logic                res_valid,
  input  logic                res_ready,
  output lspi_pkg::out_item_t res
);
  import lspi_pkg::*;

  logic busy;
  logic emit;

  assign cmd_ready = ~busy;
  assign load      = cmd_valid & cmd_ready;
  assign exec      = busy;
  // the last step holds until the result register is free
  assign emit      = busy & ucw.last & (~res_valid | res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
        res       <= result;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end

      if (!busy) begin
        if (load) begin
          busy <= 1'b1;
          step <= '0;
        end
      end else if (ucw.last) begin
        if (emit) busy <= 1'b0;
      end else if (ucw.jmp == JMP_NOT_TICK && !is_tick) begin
        step <= ucw.target;
      end else begin
        step <= step + step_t'(1);
      end
    end
  end

endmodule

// File: rtl/core/lifter_speed_pi_controller_top.sv
// channel  | signals                                   | moves
// ---------+-------------------------------------------+------------------------------
// cmd      | cmd_valid, cmd_ready, cmd                 | input item (tick/switch/goal)
// res      | res_valid, res_ready, res                 | result item, one per input
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | register write, always ready
//
// a control tick runs 12 microcode steps through one shared 33x25 multiplier;
// switch, goal and unused kinds run only dispatch and then emit.
// one item is in flight at a time.
// a new item is taken while the previous result still waits in the res register;
// the emit step stalls until that register is free.
// synchronous reset restores register defaults, the sequencer, integrator and outputs.
module lifter_speed_pi_controller_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  lspi_pkg::in_item_t     cmd,
  output logic                   res_valid,
  input  logic                   res_ready,
  output lspi_pkg::out_item_t    res,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [3:0]             cfg_index,
  input  logic [23:0]            cfg_data
);
  import lspi_pkg::*;

  cfg_t      cfg;
  step_t     step;
  ucw_t      ucw;
  out_item_t result;
  logic      load;
  logic      exec;
  logic      is_tick;

  // register file: writes are taken every cycle, unknown indexes dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_gain        <= 24'd65536;
      cfg.ki_gain        <= 24'd655360;
      cfg.integral_limit <= 24'd6554;
      cfg.sample_period  <= 24'd16777;
      cfg.speed_scale    <= 24'd409600;
      cfg.pwm_period     <= 16'd4199;
      cfg.travel_speed   <= 24'd458752;
      cfg.sign_mode      <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KP_GAIN:        cfg.kp_gain        <= cfg_data;
        CFG_KI_GAIN:        cfg.ki_gain        <= cfg_data;
        CFG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_data;
        CFG_SAMPLE_PERIOD:  cfg.sample_period  <= cfg_data;
        CFG_SPEED_SCALE:    cfg.speed_scale    <= cfg_data;
        CFG_PWM_PERIOD:     cfg.pwm_period     <= cfg_data[15:0];
        CFG_TRAVEL_SPEED:   cfg.travel_speed   <= cfg_data;
        CFG_SIGN_MODE:      cfg.sign_mode      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // control store
  lspi_ucode_rom u_rom (
    .step (step),
    .ucw  (ucw)
  );

  // step counter, jumps and the result register
  lspi_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .load      (load),
    .exec      (exec),
    .step      (step),
    .ucw       (ucw),
    .is_tick   (is_tick),
    .result    (result),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // shared multiplier, saturating adds and the controller state
  lspi_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .load    (load),
    .item    (cmd),
    .exec    (exec),
    .ucw     (ucw),
    .is_tick (is_tick),
    .result  (result)
  );

endmodule
